// ===== src/ctks_pkg.sv =====
// ctks_pkg: shared types, codes and defaults of the cosine top-k search block.
// No dependencies; used by every module under src.
package ctks_pkg;

    localparam int MAX_DIM_DEF     = 64;
    localparam int MAX_VECTORS_DEF = 1024;
    localparam int K_MAX_DEF       = 16;

    // reset value of the vector length register
    localparam logic [6:0] VLEN_RESET = 7'd64;
    // staging element count saturates here
    localparam int STAGE_SAT = 127;

    typedef enum logic [0:0] {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_MATCH     = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_LEN_ERR   = 3'd5
    } status_t;

    typedef struct packed {
        op_t                operation;
        logic [31:0]        vector_id;
        logic signed [15:0] element;
        logic               last_element;
        logic [4:0]         top_count;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [31:0]        match_id;
        logic signed [31:0] score;
        logic               last_result;
    } result_t;

    // control from the sequencer to the best-list unit
    typedef struct packed {
        logic clear;
        logic insert;
    } topk_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_DUP_RD,
        S_DUP_CMP,
        S_FULL,
        S_SQ_GO,
        S_SQ_WAIT,
        S_N_RD,
        S_N_LD,
        S_N_DIV,
        S_N_WR,
        S_SC_ISS,
        S_SC_DRAIN,
        S_SC_INS,
        S_EMIT,
        S_RESP
    } state_t;

    // address/index width of at least one bit
    function automatic int clog2m1(input int n);
        int w;
        w = (n <= 2) ? 1 : $clog2(n);
        return w;
    endfunction

endpackage

// ===== src/ctks_ram.sv =====
// ctks_ram: generic single-write, single-read RAM with registered read data.
// Depends on ctks_pkg for the address width helper.
module ctks_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [ctks_pkg::clog2m1(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [ctks_pkg::clog2m1(DEPTH)-1:0]     raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ctks_isqrt.sv =====
// ctks_isqrt: iterative integer square root, two radicand bits per cycle.
// Depends on ctks_pkg for the counter width helper.
module ctks_isqrt #(
    parameter int IN_W = 38
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [IN_W-1:0]   x,
    output logic              done,
    output logic [IN_W/2-1:0] root
);

    localparam int H  = IN_W / 2;
    localparam int RW = H + 3;
    localparam int CW = ctks_pkg::clog2m1(H);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [IN_W-1:0] x_reg;
    logic [RW-1:0] rem_reg;
    logic [H-1:0]  root_reg;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    // one digit step
    always_comb
    begin
        rem_sh = {rem_reg[RW-3:0], x_reg[IN_W-1:IN_W-2]};
        trial  = RW'({root_reg, 2'b01});
        ge     = (rem_sh >= trial);
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (int'(cnt_reg) == H - 1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[IN_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[H-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/ctks_div.sv =====
// ctks_div: restoring divider, one quotient bit per cycle.
// Depends on ctks_pkg for the counter width helper.
module ctks_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CW = ctks_pkg::clog2m1(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   tr;
    logic [DEN_W:0]   diff;
    logic             ge;

    // trial subtract
    always_comb
    begin
        tr   = {rem_reg, q_reg[NUM_W-1]};
        diff = tr - {1'b0, den_reg};
        ge   = (tr >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (int'(cnt_reg) == NUM_W - 1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : tr[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== src/ctks_topk.sv =====
// ctks_topk: sorted best-match list, insertion of one candidate per cycle.
// Depends on ctks_pkg for the control struct and width helper.
module ctks_topk #(
    parameter int K_MAX = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ctks_pkg::topk_ctrl_t                   ctrl,
    input  logic [$clog2(K_MAX+1)-1:0]             limit,
    input  logic signed [31:0]                     cand_score,
    input  logic [31:0]                            cand_id,
    input  logic [ctks_pkg::clog2m1(K_MAX)-1:0]    rd_idx,
    output logic signed [31:0]                     rd_score,
    output logic [31:0]                            rd_id,
    output logic [$clog2(K_MAX+1)-1:0]             count
);

    localparam int KW = $clog2(K_MAX + 1);

    logic signed [31:0] score_reg [K_MAX];
    logic [31:0]        id_reg    [K_MAX];
    logic [KW-1:0]      count_reg;

    logic signed [31:0] score_next [K_MAX];
    logic [31:0]        id_next    [K_MAX];
    logic [K_MAX-1:0]   gt;

    // candidate beats entry p (empty slots always lose)
    always_comb
    begin
        for (int p = 0; p < K_MAX; p++)
        begin
            gt[p] = (p >= int'(count_reg))
                    || (cand_score > score_reg[p])
                    || ((cand_score == score_reg[p]) && (cand_id < id_reg[p]));
        end
    end

    // shift lower entries down, drop candidate in at its place
    always_comb
    begin
        for (int p = 0; p < K_MAX; p++)
        begin
            score_next[p] = score_reg[p];
            id_next[p]    = id_reg[p];
            if (gt[p])
            begin
                if (p == 0)
                begin
                    score_next[p] = cand_score;
                    id_next[p]    = cand_id;
                end
                else if (!gt[p-1])
                begin
                    score_next[p] = cand_score;
                    id_next[p]    = cand_id;
                end
                else
                begin
                    score_next[p] = score_reg[p-1];
                    id_next[p]    = id_reg[p-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            count_reg <= '0;
        end
        else if (ctrl.insert && (count_reg < limit))
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            for (int p = 0; p < K_MAX; p++)
            begin
                score_reg[p] <= score_next[p];
                id_reg[p]    <= id_next[p];
            end
        end
    end

    assign rd_score = score_reg[rd_idx];
    assign rd_id    = id_reg[rd_idx];
    assign count    = count_reg;

endmodule

// ===== src/cosine_top_k_search.sv =====
// Vector store with exact top-k cosine search: sequencer, memories and datapath.
// Depends on ctks_pkg, ctks_ram, ctks_isqrt, ctks_div and ctks_topk.
// Non-last elements are accepted back to back with busy low. A last element
// holds busy for normalization (an iterative square root, then the serial
// divider for each element) and, for a query, for a scan of every stored
// vector on the single vector-memory read port, then one result per cycle.
// Refusals respond without normalizing. Reset clears counts and the best list;
// the memories are not cleared. Results are strobed and cannot be stalled.
module cosine_top_k_search #(
    parameter int MAX_DIM     = ctks_pkg::MAX_DIM_DEF,
    parameter int MAX_VECTORS = ctks_pkg::MAX_VECTORS_DEF,
    parameter int K_MAX       = ctks_pkg::K_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ctks_pkg::item_t   item,
    output logic              busy,
    output ctks_pkg::result_t result,
    output logic              result_valid,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [6:0]        cfg_data
);

    localparam int DIM_CW  = $clog2(MAX_DIM + 1);
    localparam int IDX_W   = ctks_pkg::clog2m1(MAX_DIM);
    localparam int CNT_W   = $clog2(MAX_VECTORS + 1);
    localparam int ROW_W   = ctks_pkg::clog2m1(MAX_VECTORS);
    localparam int VDEPTH  = MAX_VECTORS * MAX_DIM;
    localparam int VADDR_W = ctks_pkg::clog2m1(VDEPTH);
    localparam int SUMSQ_W = 32 + 2 * (($clog2(MAX_DIM) + 1) / 2);
    localparam int H       = SUMSQ_W / 2;
    localparam int ACC_W   = 32 + DIM_CW;
    localparam int KW      = $clog2(K_MAX + 1);
    localparam int KI      = ctks_pkg::clog2m1(K_MAX);

    // registers
    ctks_pkg::state_t    state_reg, state_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic [6:0]          vl_reg, vl_next;
    logic [CNT_W-1:0]    stored_reg, stored_next;
    logic                sqv_reg, sqv_next;
    logic [31:0]         sq_reg, sq_next;
    logic [SUMSQ_W-1:0]  sumsq_reg, sumsq_next;
    logic                out_valid_reg, out_valid_next;
    ctks_pkg::result_t   out_reg, out_next;
    logic                p1_reg, p1_next;
    logic                p2_reg, p2_next;
    logic [CNT_W-1:0]    row_reg, row_next;
    logic [DIM_CW-1:0]   col_reg, col_next;
    logic [KI-1:0]       em_reg, em_next;
    ctks_pkg::op_t       op_reg, op_next;
    logic [31:0]         vid_reg, vid_next;
    logic [4:0]          k_reg, k_next;
    logic [6:0]          len_reg, len_next;
    logic                len_ok_reg, len_ok_next;
    logic [KW-1:0]       r_reg, r_next;
    ctks_pkg::status_t   st_reg, st_next;
    logic [H-1:0]        norm_reg, norm_next;
    logic                sign_reg, sign_next;
    logic signed [15:0]  nval_reg, nval_next;
    logic signed [31:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // memory ports
    logic                stg_we, stg_re;
    logic [IDX_W-1:0]    stg_waddr, stg_raddr;
    logic [15:0]         stg_wdata, stg_rdata;
    logic                vec_we, vec_re;
    logic [VADDR_W-1:0]  vec_waddr, vec_raddr;
    logic [15:0]         vec_rdata;
    logic                id_we, id_re;
    logic [ROW_W-1:0]    id_waddr, id_raddr;
    logic [31:0]         id_rdata;

    // arithmetic units
    logic                sqrt_start, sqrt_done;
    logic [H-1:0]        sqrt_root;
    logic                div_start, div_done;
    logic [31:0]         div_num, div_quot;

    // best list
    ctks_pkg::topk_ctrl_t tk_ctrl;
    logic signed [31:0]  tk_rd_score;
    logic [31:0]         tk_rd_id;
    logic [KW-1:0]       tk_count;

    // helpers
    logic                accept;
    logic [7:0]          total;
    logic                len_ok_now;
    logic signed [31:0]  elem_ext;
    logic signed [16:0]  e17;
    logic [16:0]         mag;
    logic [14:0]         q15;
    logic [KW-1:0]       kcl;
    logic [KW-1:0]       rmin;
    logic signed [31:0]  acc_sat;
    logic [ACC_W-32:0]   acc_top;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ctks_pkg::S_IDLE);
    assign cfg_ready = 1'b1;

    // length check and element square for the incoming item
    always_comb
    begin
        total      = {1'b0, cnt_reg} + 8'd1;
        len_ok_now = (total == {1'b0, vl_reg}) && (vl_reg != 7'd0)
                     && (int'(vl_reg) <= MAX_DIM);
        elem_ext   = 32'(item.element);
    end

    // normalization operands
    always_comb
    begin
        e17     = 17'($signed(stg_rdata));
        mag     = e17[16] ? 17'(-e17) : 17'(e17);
        div_num = (32'(mag) << 15) + 32'(norm_reg >> 1);
        q15     = (div_quot > 32'd32767) ? 15'h7fff : div_quot[14:0];
    end

    // effective k
    always_comb
    begin
        if (int'(k_reg) > K_MAX)
        begin
            kcl = KW'(K_MAX);
        end
        else
        begin
            kcl = KW'(k_reg);
        end
        if (int'(stored_reg) < int'(kcl))
        begin
            rmin = KW'(stored_reg);
        end
        else
        begin
            rmin = kcl;
        end
    end

    // score saturation to Q2.30 range
    always_comb
    begin
        acc_top = acc_reg[ACC_W-1:31];
        if ((&acc_top) || !(|acc_top))
        begin
            acc_sat = acc_reg[31:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            acc_sat = 32'sh8000_0000;
        end
        else
        begin
            acc_sat = 32'sh7fff_ffff;
        end
    end

    // sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        vl_next        = cfg_valid ? cfg_data : vl_reg;
        stored_next    = stored_reg;
        sqv_next       = 1'b0;
        sq_next        = sq_reg;
        sumsq_next     = sumsq_reg + (sqv_reg ? SUMSQ_W'(sq_reg) : '0);
        out_valid_next = 1'b0;
        out_next       = out_reg;
        p1_next        = 1'b0;
        p2_next        = p1_reg;
        prod_next      = p1_reg ? (32'($signed(stg_rdata)) * 32'($signed(vec_rdata)))
                                : prod_reg;
        acc_next       = acc_reg + (p2_reg ? ACC_W'(prod_reg) : '0);
        row_next       = row_reg;
        col_next       = col_reg;
        em_next        = em_reg;
        op_next        = op_reg;
        vid_next       = vid_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        len_ok_next    = len_ok_reg;
        r_next         = r_reg;
        st_next        = st_reg;
        norm_next      = norm_reg;
        sign_next      = sign_reg;
        nval_next      = nval_reg;

        stg_we    = 1'b0;
        stg_waddr = IDX_W'(cnt_reg);
        stg_wdata = item.element;
        stg_re    = 1'b0;
        stg_raddr = IDX_W'(col_reg);
        vec_we    = 1'b0;
        vec_waddr = VADDR_W'(32'(stored_reg) * 32'(MAX_DIM) + 32'(col_reg));
        vec_re    = 1'b0;
        vec_raddr = VADDR_W'(32'(row_reg) * 32'(MAX_DIM) + 32'(col_reg));
        id_we     = 1'b0;
        id_waddr  = ROW_W'(stored_reg);
        id_re     = 1'b0;
        id_raddr  = ROW_W'(row_reg);
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        tk_ctrl    = '0;

        unique case (state_reg)
            ctks_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    // buffer the element and its square
                    if (int'(cnt_reg) < MAX_DIM)
                    begin
                        stg_we   = 1'b1;
                        sqv_next = 1'b1;
                        sq_next  = elem_ext * elem_ext;
                    end
                    if (item.last_element)
                    begin
                        cnt_next    = '0;
                        op_next     = item.operation;
                        vid_next    = item.vector_id;
                        k_next      = item.top_count;
                        len_next    = vl_reg;
                        len_ok_next = len_ok_now;
                        state_next  = ctks_pkg::S_DECIDE;
                    end
                    else if (int'(cnt_reg) < ctks_pkg::STAGE_SAT)
                    begin
                        cnt_next = cnt_reg + 7'd1;
                    end
                end
            end

            ctks_pkg::S_DECIDE:
            begin
                r_next   = rmin;
                row_next = '0;
                if (op_reg == ctks_pkg::OP_ADD)
                begin
                    if (!len_ok_reg)
                    begin
                        st_next    = ctks_pkg::ST_LEN_ERR;
                        state_next = ctks_pkg::S_RESP;
                    end
                    else if (stored_reg == '0)
                    begin
                        state_next = ctks_pkg::S_FULL;
                    end
                    else
                    begin
                        state_next = ctks_pkg::S_DUP_RD;
                    end
                end
                else
                begin
                    if (k_reg == 5'd0)
                    begin
                        st_next    = ctks_pkg::ST_EMPTY;
                        state_next = ctks_pkg::S_RESP;
                    end
                    else if (!len_ok_reg)
                    begin
                        st_next    = ctks_pkg::ST_LEN_ERR;
                        state_next = ctks_pkg::S_RESP;
                    end
                    else if (rmin == '0)
                    begin
                        st_next    = ctks_pkg::ST_EMPTY;
                        state_next = ctks_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = ctks_pkg::S_SQ_GO;
                    end
                end
            end

            // duplicate id scan over the id memory
            ctks_pkg::S_DUP_RD:
            begin
                id_re      = 1'b1;
                state_next = ctks_pkg::S_DUP_CMP;
            end

            ctks_pkg::S_DUP_CMP:
            begin
                if (id_rdata == vid_reg)
                begin
                    st_next    = ctks_pkg::ST_DUPLICATE;
                    state_next = ctks_pkg::S_RESP;
                end
                else if (int'(row_reg) + 1 == int'(stored_reg))
                begin
                    state_next = ctks_pkg::S_FULL;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = ctks_pkg::S_DUP_RD;
                end
            end

            ctks_pkg::S_FULL:
            begin
                if (int'(stored_reg) >= MAX_VECTORS)
                begin
                    st_next    = ctks_pkg::ST_FULL;
                    state_next = ctks_pkg::S_RESP;
                end
                else
                begin
                    state_next = ctks_pkg::S_SQ_GO;
                end
            end

            // norm of the staged vector
            ctks_pkg::S_SQ_GO:
            begin
                sqrt_start = 1'b1;
                state_next = ctks_pkg::S_SQ_WAIT;
            end

            ctks_pkg::S_SQ_WAIT:
            begin
                if (sqrt_done)
                begin
                    norm_next  = sqrt_root;
                    col_next   = '0;
                    state_next = ctks_pkg::S_N_RD;
                end
            end

            // per-element normalization
            ctks_pkg::S_N_RD:
            begin
                if (int'(col_reg) < int'(len_reg))
                begin
                    stg_re = 1'b1;
                end
                state_next = ctks_pkg::S_N_LD;
            end

            ctks_pkg::S_N_LD:
            begin
                if ((int'(col_reg) >= int'(len_reg)) || (norm_reg == '0))
                begin
                    nval_next  = '0;
                    state_next = ctks_pkg::S_N_WR;
                end
                else
                begin
                    sign_next  = stg_rdata[15];
                    div_start  = 1'b1;
                    state_next = ctks_pkg::S_N_DIV;
                end
            end

            ctks_pkg::S_N_DIV:
            begin
                if (div_done)
                begin
                    nval_next  = sign_reg ? -$signed({1'b0, q15}) : $signed({1'b0, q15});
                    state_next = ctks_pkg::S_N_WR;
                end
            end

            ctks_pkg::S_N_WR:
            begin
                if (op_reg == ctks_pkg::OP_ADD)
                begin
                    // stored rows are zero-padded to full width
                    vec_we = 1'b1;
                    if (int'(col_reg) == MAX_DIM - 1)
                    begin
                        id_we       = 1'b1;
                        stored_next = stored_reg + 1'b1;
                        st_next     = ctks_pkg::ST_ADDED;
                        state_next  = ctks_pkg::S_RESP;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = ctks_pkg::S_N_RD;
                    end
                end
                else
                begin
                    // normalized query goes back into the staging buffer
                    stg_we    = 1'b1;
                    stg_waddr = IDX_W'(col_reg);
                    stg_wdata = nval_reg;
                    if (int'(col_reg) == int'(len_reg) - 1)
                    begin
                        tk_ctrl.clear = 1'b1;
                        row_next      = '0;
                        col_next      = '0;
                        acc_next      = '0;
                        state_next    = ctks_pkg::S_SC_ISS;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = ctks_pkg::S_N_RD;
                    end
                end
            end

            // dot product of one stored row, one element per cycle
            ctks_pkg::S_SC_ISS:
            begin
                stg_re  = 1'b1;
                vec_re  = 1'b1;
                p1_next = 1'b1;
                if (col_reg == '0)
                begin
                    id_re = 1'b1;
                end
                if (int'(col_reg) == int'(len_reg) - 1)
                begin
                    state_next = ctks_pkg::S_SC_DRAIN;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end

            ctks_pkg::S_SC_DRAIN:
            begin
                if (!p1_reg && !p2_reg)
                begin
                    state_next = ctks_pkg::S_SC_INS;
                end
            end

            ctks_pkg::S_SC_INS:
            begin
                tk_ctrl.insert = 1'b1;
                acc_next       = '0;
                col_next       = '0;
                em_next        = '0;
                if (int'(row_reg) + 1 == int'(stored_reg))
                begin
                    state_next = ctks_pkg::S_EMIT;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = ctks_pkg::S_SC_ISS;
                end
            end

            // matches, best first
            ctks_pkg::S_EMIT:
            begin
                out_valid_next       = 1'b1;
                out_next.status      = ctks_pkg::ST_MATCH;
                out_next.match_id    = tk_rd_id;
                out_next.score       = tk_rd_score;
                out_next.last_result = (int'(em_reg) + 1 == int'(tk_count));
                if (int'(em_reg) + 1 == int'(tk_count))
                begin
                    sumsq_next = '0;
                    state_next = ctks_pkg::S_IDLE;
                end
                else
                begin
                    em_next = em_reg + 1'b1;
                end
            end

            ctks_pkg::S_RESP:
            begin
                out_valid_next       = 1'b1;
                out_next.status      = st_reg;
                out_next.match_id    = '0;
                out_next.score       = '0;
                out_next.last_result = 1'b1;
                sumsq_next           = '0;
                state_next           = ctks_pkg::S_IDLE;
            end

            default:
            begin
                state_next = ctks_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctks_pkg::S_IDLE;
            cnt_reg       <= '0;
            vl_reg        <= ctks_pkg::VLEN_RESET;
            stored_reg    <= '0;
            sqv_reg       <= 1'b0;
            sumsq_reg     <= '0;
            out_valid_reg <= 1'b0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            em_reg        <= '0;
            len_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            vl_reg        <= vl_next;
            stored_reg    <= stored_next;
            sqv_reg       <= sqv_next;
            sumsq_reg     <= sumsq_next;
            out_valid_reg <= out_valid_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            em_reg        <= em_next;
            len_ok_reg    <= len_ok_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        out_reg  <= out_next;
        op_reg   <= op_next;
        vid_reg  <= vid_next;
        k_reg    <= k_next;
        len_reg  <= len_next;
        r_reg    <= r_next;
        st_reg   <= st_next;
        norm_reg <= norm_next;
        sign_reg <= sign_next;
        nval_reg <= nval_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // staging buffer: raw elements, then the normalized query
    ctks_ram #(
        .WIDTH (16),
        .DEPTH (MAX_DIM)
    ) u_stage_ram (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .re    (stg_re),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    // normalized stored vectors, one row of MAX_DIM per entry
    ctks_ram #(
        .WIDTH (16),
        .DEPTH (VDEPTH)
    ) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (nval_reg),
        .re    (vec_re),
        .raddr (vec_raddr),
        .rdata (vec_rdata)
    );

    ctks_ram #(
        .WIDTH (32),
        .DEPTH (MAX_VECTORS)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (vid_reg),
        .re    (id_re),
        .raddr (id_raddr),
        .rdata (id_rdata)
    );

    ctks_isqrt #(
        .IN_W (SUMSQ_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (sumsq_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    ctks_div #(
        .NUM_W (32),
        .DEN_W (H)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (norm_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    ctks_topk #(
        .K_MAX (K_MAX)
    ) u_topk (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (tk_ctrl),
        .limit      (r_reg),
        .cand_score (acc_sat),
        .cand_id    (id_rdata),
        .rd_idx     (em_reg),
        .rd_score   (tk_rd_score),
        .rd_id      (tk_rd_id),
        .count      (tk_count)
    );

`ifndef SYNTHESIS
    // the final result of a run leaves the block ready for the next item
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |-> !busy)
        else $error("busy after final result");

    // only matches come in runs longer than one
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ctks_pkg::ST_MATCH) |-> result.last_result)
        else $error("refusal not marked final");

    // the store grows only with an added status
    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (stored_reg != $past(stored_reg)) |=>
            result_valid && (result.status == ctks_pkg::ST_ADDED))
        else $error("store grew without added status");

    // processing starts only from a last-element transfer
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && item.last_element))
        else $error("busy without last element");
`endif

endmodule
